### rtl/ergh_pkg.sv
// Shared types, constants and sample functions of the echo-reference gate.
package ergh_pkg;

	// Number of reference channels that are tested and processed
	localparam int REF_CHANNELS = 2;

	// Configuration register indexes (byte address is four times the index)
	localparam logic [1:0] REG_GATE_ENABLE = 2'd0;
	localparam logic [1:0] REG_LEVEL_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_HOLD_SAMPLES = 2'd2;

	// Register reset values
	localparam logic RST_GATE_ENABLE = 1'b1;
	localparam logic [14:0] RST_LEVEL_THRESHOLD = 15'd16384;
	localparam logic [15:0] RST_HOLD_SAMPLES = 16'd480;

	// Saturation limit of the quiet run
	localparam logic [16:0] RUN_MAX = 17'h1ffff;

	// Reciprocal of five scaled by 2^18, exact for magnitudes up to 32768
	localparam logic [31:0] DIV5_RECIP = 32'd52429;
	localparam int DIV5_SHIFT = 18;

	// Frame processing mode chosen at frame close
	typedef enum logic [1:0] {
		MODE_PASS,
		MODE_SCALE,
		MODE_ZERO
	} mode_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_FILL,
		ST_READ,
		ST_LOAD,
		ST_SHOW
	} state_t;

	// Configuration register file contents
	typedef struct packed {
		logic gate_enable;
		logic [14:0] level_threshold;
		logic [15:0] hold_samples;
	} cfg_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic rd_first;
		logic rd_next;
		logic load;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic close;
		logic last;
	} stat_t;

	// Saturated magnitude: the most negative code counts as full scale
	function automatic logic [14:0] ref_mag(input logic signed [15:0] x);
		logic [15:0] a;
		a = x[15] ? 16'(~unsigned'(x) + 16'd1) : unsigned'(x);
		if (a[15]) begin
			return 15'h7fff;
		end
		return a[14:0];
	endfunction

	// Apply the frame mode to one sample; scaling truncates toward zero
	function automatic logic signed [15:0] gate_sample(input logic signed [15:0] x,
			input mode_t mode);
		logic [15:0] m;
		logic [31:0] p;
		logic [15:0] q;
		logic signed [15:0] y;
		m = x[15] ? 16'(~unsigned'(x) + 16'd1) : unsigned'(x);
		p = 32'(m) * DIV5_RECIP;
		q = 16'(p[31:DIV5_SHIFT]);
		case (mode)
			MODE_PASS: y = x;
			MODE_SCALE: y = x[15] ? signed'(16'(~q + 16'd1)) : signed'(q);
			MODE_ZERO: y = 16'sd0;
			default: y = 16'sd0;
		endcase
		return y;
	endfunction

endpackage

### rtl/ergh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ergh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/ergh_ctrl.sv
// Controller: sequences frame fill, store readout and result words.
module ergh_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic out_stall,
	input ergh_pkg::stat_t stat,
	output ergh_pkg::cmd_t cmd,
	output logic in_stall,
	output logic out_valid
);

	import ergh_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FILL: begin
				if (in_valid && stat.close) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_LOAD;
			ST_LOAD: state_d = ST_SHOW;
			ST_SHOW: begin
				if (!out_stall) begin
					state_d = stat.last ? ST_FILL : ST_LOAD;
				end
			end
			default: state_d = ST_FILL;
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_FILL: begin
				in_stall = 1'b0;
				cmd.accept = in_valid;
			end
			ST_READ: cmd.rd_first = 1'b1;
			ST_LOAD: cmd.load = 1'b1;
			ST_SHOW: begin
				out_valid = 1'b1;
				cmd.rd_next = !out_stall && !stat.last;
			end
			default: in_stall = 1'b1;
		endcase
	end

endmodule

### rtl/ergh_dp.sv
// Datapath: frame store, level detection, hold logic and output word register.
module ergh_dp #(
	parameter int FRAME_MAX = 64
) (
	input logic clk,
	input logic arst_n,
	input ergh_pkg::cfg_t cfg,
	input ergh_pkg::cmd_t cmd,
	input logic signed [15:0] ref_sample_first,
	input logic signed [15:0] ref_sample_second,
	input logic frame_end,
	output ergh_pkg::stat_t stat,
	output logic signed [15:0] out_sample_first,
	output logic signed [15:0] out_sample_second,
	output logic last_of_frame
);

	import ergh_pkg::*;

	localparam int AW = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(FRAME_MAX - 1);

	logic [AW-1:0] fill_q;
	logic [AW-1:0] last_idx_q;
	logic [AW-1:0] rd_idx_q;
	logic loud_q;
	logic [16:0] quiet_q;
	mode_t mode_q;

	logic cur_loud;
	logic loud_now;
	logic [AW:0] frame_len;
	logic [17:0] run_sum;
	logic [AW-1:0] raddr;
	logic [31:0] rdata;
	logic signed [15:0] raw_first;
	logic signed [15:0] raw_second;

	// Level test of the incoming slice
	always_comb begin
		cur_loud = ref_mag(ref_sample_first) > cfg.level_threshold;
		if (REF_CHANNELS > 1 && ref_mag(ref_sample_second) > cfg.level_threshold) begin
			cur_loud = 1'b1;
		end
	end

	assign loud_now = loud_q | cur_loud;
	assign frame_len = {1'b0, fill_q} + {{AW{1'b0}}, 1'b1};
	assign run_sum = {1'b0, quiet_q} + 18'(frame_len);

	// A full store closes the frame as well
	assign stat.close = frame_end || (fill_q == LAST_SLOT);
	assign stat.last = (rd_idx_q == last_idx_q);

	// Fill, close and hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			loud_q <= 1'b0;
			quiet_q <= '0;
			mode_q <= MODE_PASS;
			last_idx_q <= '0;
		end else if (cmd.accept) begin
			if (stat.close) begin
				fill_q <= '0;
				loud_q <= 1'b0;
				last_idx_q <= fill_q;
				if (!cfg.gate_enable) begin
					mode_q <= MODE_PASS;
				end else if (loud_now) begin
					quiet_q <= '0;
					mode_q <= MODE_SCALE;
				end else if (quiet_q < {1'b0, cfg.hold_samples}) begin
					quiet_q <= run_sum[17] ? RUN_MAX : run_sum[16:0];
					mode_q <= MODE_SCALE;
				end else begin
					mode_q <= MODE_ZERO;
				end
			end else begin
				fill_q <= fill_q + AW'(1);
				loud_q <= loud_now;
			end
		end
	end

	// Readout index: restart at frame close, advance on each read after the first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.accept && stat.close) begin
			rd_idx_q <= '0;
		end else if (cmd.rd_next) begin
			rd_idx_q <= rd_idx_q + AW'(1);
		end
	end

	assign raddr = cmd.rd_next ? (rd_idx_q + AW'(1)) : rd_idx_q;

	ergh_ram #(
		.WIDTH(32),
		.DEPTH(FRAME_MAX)
	) u_store (
		.clk(clk),
		.we(cmd.accept),
		.waddr(fill_q),
		.wdata({ref_sample_second, ref_sample_first}),
		.re(cmd.rd_first | cmd.rd_next),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign raw_first = signed'(rdata[15:0]);
	assign raw_second = signed'(rdata[31:16]);

	// Output word register, loaded in the cycle after each store read
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_sample_first <= gate_sample(raw_first, mode_q);
			out_sample_second <= (REF_CHANNELS > 1) ? gate_sample(raw_second, mode_q)
				: raw_second;
			last_of_frame <= stat.last;
		end
	end

endmodule

### rtl/echo_reference_gate_with_hold_core.sv
// Top level of the echo-reference gate with hold: register port, controller, datapath.
// Throughput: one slice per cycle while a frame fills; once the closing slice is taken the
// controller steps through its read, load and show states to offer the first result word,
// then alternates load and show for each further word, since each word is read from the
// store and then loaded; a stalled word holds in show. Input stalls while a frame drains.
// Reset clears control state and loads register defaults; the store is not cleared.
module echo_reference_gate_with_hold_core #(
	parameter int FRAME_MAX = 64
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input logic signed [15:0] ref_sample_first,
	input logic signed [15:0] ref_sample_second,
	input logic frame_end,
	output logic out_valid,
	input logic out_stall,
	output logic signed [15:0] out_sample_first,
	output logic signed [15:0] out_sample_second,
	output logic last_of_frame
);

	import ergh_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	stat_t stat;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate_enable <= RST_GATE_ENABLE;
			cfg_q.level_threshold <= RST_LEVEL_THRESHOLD;
			cfg_q.hold_samples <= RST_HOLD_SAMPLES;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_GATE_ENABLE: cfg_q.gate_enable <= pwdata[0];
				REG_LEVEL_THRESHOLD: cfg_q.level_threshold <= pwdata[14:0];
				REG_HOLD_SAMPLES: cfg_q.hold_samples <= pwdata[15:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Register read decode
	always_comb begin
		unique case (paddr[3:2])
			REG_GATE_ENABLE: prdata = {31'd0, cfg_q.gate_enable};
			REG_LEVEL_THRESHOLD: prdata = {17'd0, cfg_q.level_threshold};
			REG_HOLD_SAMPLES: prdata = {16'd0, cfg_q.hold_samples};
			default: prdata = 32'd0;
		endcase
	end

	ergh_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.out_stall(out_stall),
		.stat(stat),
		.cmd(cmd),
		.in_stall(in_stall),
		.out_valid(out_valid)
	);

	ergh_dp #(
		.FRAME_MAX(FRAME_MAX)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd(cmd),
		.ref_sample_first(ref_sample_first),
		.ref_sample_second(ref_sample_second),
		.frame_end(frame_end),
		.stat(stat),
		.out_sample_first(out_sample_first),
		.out_sample_second(out_sample_second),
		.last_of_frame(last_of_frame)
	);

endmodule

### rtl/ergh_chk.sv
// Port-level checker of the echo-reference gate, bound to the top level.
module ergh_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic frame_end,
	input logic out_valid,
	input logic out_stall,
	input logic signed [15:0] out_sample_first,
	input logic signed [15:0] out_sample_second,
	input logic last_of_frame
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_sample_first)
			&& $stable(out_sample_second) && $stable(last_of_frame))
		else $error("stalled result word changed");

	// No slice is taken while a frame drains
	a_no_fill_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result words pending");

	// A closing slice stops the input on the next cycle
	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && frame_end |=> in_stall)
		else $error("input not stalled after frame end");

	// The last word of a frame ends the burst
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_of_frame |=> !out_valid && !in_stall)
		else $error("results continue past last word of frame");

endmodule

bind echo_reference_gate_with_hold_core ergh_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.frame_end(frame_end),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_sample_first(out_sample_first),
	.out_sample_second(out_sample_second),
	.last_of_frame(last_of_frame)
);

### tb/sv/ergh_checker.sv
// Checker of the echo-reference gate: predicts every emitted frame and compares it word by word.
module ergh_checker #(
	parameter int FRAME_MAX = 64
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic pready,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	input logic in_valid,
	input logic in_stall,
	input logic signed [15:0] ref_sample_first,
	input logic signed [15:0] ref_sample_second,
	input logic frame_end,
	input logic out_valid,
	input logic out_stall,
	input logic signed [15:0] out_sample_first,
	input logic signed [15:0] out_sample_second,
	input logic last_of_frame,
	output int err_count,
	output int outstanding
);

	import ergh_pkg::*;

	localparam int GAIN_DIV = 5;
	localparam int FULL_SCALE = 32767;

	typedef struct packed {
		logic signed [15:0] first;
		logic signed [15:0] second;
		logic last;
	} word_t;

	// Register shadow
	logic gate_on;
	logic [14:0] threshold;
	logic [15:0] hold_len;

	// Frame being collected and hangover state
	logic signed [15:0] held_first [FRAME_MAX];
	logic signed [15:0] held_second [FRAME_MAX];
	int fill;
	logic loud;
	logic [16:0] quiet_run;

	// Words still owed by the block, oldest first
	word_t due_words[$];
	word_t due;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		err_count++;
	endtask

	// Saturated magnitude: the most negative code counts as full scale
	function automatic int level_of(input logic signed [15:0] x);
		int m;
		m = (x < 0) ? -int'(x) : int'(x);
		return (m > FULL_SCALE) ? FULL_SCALE : m;
	endfunction

	// Apply the frame mode; division truncates toward zero
	function automatic logic signed [15:0] shaped(input logic signed [15:0] x, input mode_t mode);
		int v;
		v = x;
		case (mode)
			MODE_SCALE: v = v / GAIN_DIV;
			MODE_ZERO: v = 0;
			default: ;
		endcase
		return 16'(v);
	endfunction

	// Buffer one slice; on frame close decide the mode and queue the whole frame
	task automatic absorb_slice(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic closing_in);
		logic closing;
		logic active;
		mode_t mode;
		int n;
		int grown;
		word_t w;
		closing = closing_in;
		held_first[fill] = a;
		held_second[fill] = b;
		fill++;
		if (level_of(a) > threshold) begin
			loud = 1'b1;
		end
		if (REF_CHANNELS > 1 && level_of(b) > threshold) begin
			loud = 1'b1;
		end
		// A full store closes the frame on its own
		if (fill >= FRAME_MAX) begin
			closing = 1'b1;
		end
		if (closing) begin
			n = fill;
			mode = MODE_PASS;
			if (gate_on) begin
				active = loud;
				if (active) begin
					quiet_run = '0;
				end else if (quiet_run < hold_len) begin
					active = 1'b1;
					grown = quiet_run + n;
					quiet_run = (grown > RUN_MAX) ? RUN_MAX : 17'(grown);
				end
				mode = active ? MODE_SCALE : MODE_ZERO;
			end
			for (int k = 0; k < n; k++) begin
				w.first = shaped(held_first[k], mode);
				w.second = (REF_CHANNELS > 1) ? shaped(held_second[k], mode) : held_second[k];
				w.last = (k == n - 1);
				due_words.push_back(w);
			end
			fill = 0;
			loud = 1'b0;
		end
	endtask

	// Follow register writes, predict accepted slices, check emitted words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_on = RST_GATE_ENABLE;
			threshold = RST_LEVEL_THRESHOLD;
			hold_len = RST_HOLD_SAMPLES;
			fill = 0;
			loud = 1'b0;
			quiet_run = '0;
			due_words.delete();
			err_count = 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_GATE_ENABLE: gate_on = pwdata[0];
					REG_LEVEL_THRESHOLD: threshold = pwdata[14:0];
					REG_HOLD_SAMPLES: hold_len = pwdata[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				absorb_slice(ref_sample_first, ref_sample_second, frame_end);
			end
			if (out_valid && !out_stall) begin
				if (due_words.size() == 0) begin
					report_mismatch($sformatf("word with nothing owed: %0d %0d last %0b",
						out_sample_first, out_sample_second, last_of_frame));
				end else begin
					due = due_words.pop_front();
					if (out_sample_first !== due.first) begin
						report_mismatch($sformatf("first sample %0d, predicted %0d",
							out_sample_first, due.first));
					end
					if (out_sample_second !== due.second) begin
						report_mismatch($sformatf("second sample %0d, predicted %0d",
							out_sample_second, due.second));
					end
					if (last_of_frame !== due.last) begin
						report_mismatch($sformatf("frame end flag %0b, predicted %0b",
							last_of_frame, due.last));
					end
				end
			end
			outstanding <= due_words.size();
		end
	end

endmodule

### tb/sv/echo_reference_gate_with_hold_core_tb.sv
// Testbench top of the echo-reference gate: clock, reset, stimulus, register setup and verdict.
module echo_reference_gate_with_hold_core_tb;
	import ergh_pkg::*;

	localparam int FRAME_MAX = 64;
	localparam int IDLE_PCT = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] ref_sample_first = '0;
	logic signed [15:0] ref_sample_second = '0;
	logic frame_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] out_sample_first;
	logic signed [15:0] out_sample_second;
	logic last_of_frame;
	int err_count;
	int outstanding;

	// Stimulus bookkeeping
	bit steady = 1'b0;
	logic [14:0] cur_threshold = RST_LEVEL_THRESHOLD;
	int slices_sent = 0;
	int frames_sent = 0;
	int settings_used = 1;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	echo_reference_gate_with_hold_core #(.FRAME_MAX(FRAME_MAX)) u_top (.*);

	ergh_checker #(.FRAME_MAX(FRAME_MAX)) u_checker (.*);

	// Stall the output side at random unless in a steady stretch
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	// Register write: setup cycle, then access cycle until pready
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one slice, with random idle cycles ahead of it
	task automatic send_slice(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic fe);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ref_sample_first <= a;
		ref_sample_second <= b;
		frame_end <= fe;
		do @(posedge clk); while (in_stall);
		slices_sent++;
	endtask

	// Loud draws cover the full range; quiet draws stay at or below the threshold
	function automatic logic signed [15:0] draw_sample(input bit loud);
		logic [15:0] m;
		if (loud) begin
			case ($urandom_range(9))
				0: return 16'sh8000;
				1: return 16'sh7fff;
				default: return 16'($urandom);
			endcase
		end
		m = 16'($urandom_range(0, cur_threshold));
		return ($urandom_range(1) != 0) ? -signed'(m) : signed'(m);
	endfunction

	task automatic send_frame(input int len, input bit loud, input bit mark_end);
		for (int k = 0; k < len; k++) begin
			send_slice(draw_sample(loud), draw_sample(loud), (k == len - 1) ? mark_end : 1'b0);
		end
		frames_sent++;
	endtask

	// Mostly short frames, a few up to a full store
	task automatic random_frames(input int count);
		int stop_at;
		int len;
		int pick;
		stop_at = slices_sent + count;
		while (slices_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				len = $urandom_range(1, 6);
			end else if (pick < 95) begin
				len = $urandom_range(7, 24);
			end else begin
				len = $urandom_range(25, FRAME_MAX);
			end
			send_frame(len, $urandom_range(99) < 35, (len < FRAME_MAX) || ($urandom_range(1) != 0));
		end
	endtask

	// Hold the sender until every owed word has come, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic setup(input logic gate, input logic [14:0] th, input logic [15:0] hold);
		drain();
		write_reg(REG_GATE_ENABLE, 32'(gate));
		write_reg(REG_LEVEL_THRESHOLD, 32'(th));
		write_reg(REG_HOLD_SAMPLES, 32'(hold));
		cur_threshold = th;
		settings_used++;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Loud frame at the extremes, most negative code included
		send_slice(16'sh8000, 16'sh7fff, 1'b0);
		send_slice(16385, -16385, 1'b0);
		send_slice(-1, 1, 1'b0);
		send_slice(7, -7, 1'b1);
		// Quiet frame sitting exactly on the threshold: kept active by the hold
		send_slice(16384, -16384, 1'b0);
		send_slice(-16384, 0, 1'b0);
		send_slice(4, -4, 1'b1);
		// Single-slice frames, loud on one channel only
		send_slice(0, 16'sh8000, 1'b1);
		send_slice(-16385, 100, 1'b1);
		frames_sent += 4;

		// Gating off: frames pass unchanged, quiet run kept
		setup(1'b0, 15'd0, 16'd0);
		send_slice(16'sh7fff, 16'sh8000, 1'b0);
		send_slice(-5, 3, 1'b1);
		// Zero threshold and zero hold: silence is muted, anything else is loud
		setup(1'b1, 15'd0, 16'd0);
		send_slice(0, 0, 1'b0);
		send_slice(0, 0, 1'b1);
		send_slice(1, 0, 1'b1);
		send_slice(0, 0, 1'b1);
		// Top threshold and longest hold: nothing is loud, hold keeps frames active
		setup(1'b1, 15'd32767, 16'd65535);
		send_slice(16'sh8000, 16'sh7fff, 1'b1);
		frames_sent += 5;

		// Steady stretch with no idling, including a frame closed by a full store
		steady = 1'b1;
		random_frames(30);
		send_frame(FRAME_MAX, 1'b0, 1'b0);
		steady = 1'b0;

		// Short hold so the hangover runs out between loud frames
		setup(1'b1, 15'($urandom_range(1000, 20000)), 16'd20);
		random_frames(45);

		repeat (2) begin
			setup(1'($urandom_range(1)), 15'($urandom_range(0, 32767)),
				16'($urandom_range(0, 100)));
			random_frames(35);
		end

		drain();
		$display("Run covered %0d slices in %0d frames over %0d register settings,",
			slices_sent, frames_sent, settings_used);
		$display("with gating off, hold expiry, threshold extremes and a full-store close.");
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Hard stop if the block hangs
	initial begin
		#400000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
